[sv/cro_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cro_pkg;

  // Defaults for the top-level parameters.
  localparam int VERTEX_COUNT_DEF  = 8;
  localparam int FRACTION_BITS_DEF = 16;

  // Fixed datapath widths.
  localparam int COORD_W   = 32;                  // one stored coordinate
  localparam int COEF_W    = 18;                  // Q1.16 register
  localparam int COEF_BITS = 16;                  // fraction bits of a register
  localparam int SIN_W     = COEF_W + 1;          // sine after optional negation
  localparam int PROD_W    = COORD_W + SIN_W;     // rotation product
  localparam int SUM_W     = PROD_W + 1;          // sum of two products
  localparam int ROT_W     = SUM_W - COEF_BITS;   // sum after the shift
  localparam int PPROD_W   = COORD_W + COEF_W;    // projection product
  localparam int PQ_W      = PPROD_W - COEF_BITS; // projection product after shift
  localparam int PX_W      = PQ_W + 1;            // projected coordinate
  localparam int SCREEN_W  = 11;
  localparam int REG_IDX_W = 2;
  localparam int CUBE_SIDE = 100;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_COS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KX  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_KY  = 2'd3;

  // Register reset values.
  localparam logic [COEF_W-1:0] COS_RESET = 18'd56749;
  localparam logic [COEF_W-1:0] SIN_RESET = 18'd32780;
  localparam logic [COEF_W-1:0] KX_RESET  = 18'd32732;
  localparam logic [COEF_W-1:0] KY_RESET  = 18'd18907;

  // Axis codes of a command.
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic [SCREEN_W-1:0] SCREEN_MAX = 11'h3FF;
  localparam logic [SCREEN_W-1:0] SCREEN_MIN = 11'h400;

  typedef struct packed {
    logic [1:0] axis;
    logic       direction;
  } cro_cmd_t;

  typedef struct packed {
    logic [2:0]          vertex_index;
    logic [SCREEN_W-1:0] screen_x;
    logic [SCREEN_W-1:0] screen_y;
    logic                last_vertex;
  } cro_result_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } vertex_t;

  // Control that travels with a vertex down the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } cro_tag_t;

  // Cube corner that a vertex holds after reset.
  function automatic vertex_t cube_corner(input int unsigned idx, input int unsigned fb);
    logic [COORD_W-1:0] side;
    logic [1:0]         m;
    vertex_t            v;
    side = COORD_W'(CUBE_SIDE) << fb;
    m    = idx[1:0];
    v.x  = (m == 2'd1 || m == 2'd2) ? side : '0;
    v.y  = m[1] ? side : '0;
    v.z  = idx[2] ? side : '0;
    return v;
  endfunction

  // Clamp a shifted sum to the signed 32-bit range.
  function automatic logic [COORD_W-1:0] sat_coord(input logic [ROT_W-1:0] v);
    logic [ROT_W-COORD_W:0] top;
    top = v[ROT_W-1:COORD_W-1];
    if (&top || ~|top) begin
      return v[COORD_W-1:0];
    end else if (v[ROT_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

[sv/cro_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module cro_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/cro_rotate.sv]
`timescale 1ns / 1ps
`default_nettype none

module cro_rotate
  import cro_pkg::*;
#(
  parameter int IDX_W = 3
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [1:0]          axis,
  input  wire logic [COEF_W-1:0]   cos_rot,
  input  wire logic [SIN_W-1:0]    sin_s,
  input  wire cro_tag_t            tag_in,
  input  wire logic [IDX_W-1:0]    idx_in,
  input  wire vertex_t             vert_in,
  output cro_tag_t                 tag_out,
  output logic      [IDX_W-1:0]    idx_out,
  output vertex_t                  vert_out
);

  logic [COORD_W-1:0] a, b;
  logic [PROD_W-1:0]  a_ext, b_ext, c_ext, s_ext;

  // Products stage.
  cro_tag_t          tag_m;
  logic [IDX_W-1:0]  idx_m;
  vertex_t           vert_m;
  logic [PROD_W-1:0] p_ac, p_bs, p_as, p_bc;

  logic [SUM_W-1:0]   sum_a, sum_b;
  logic [COORD_W-1:0] ra, rb;
  vertex_t            vert_next;

  // The rotated pair: a is the first coordinate, b the second.
  always_comb begin
    case (axis)
      AXIS_X: begin
        a = vert_in.y;
        b = vert_in.z;
      end
      AXIS_Y: begin
        a = vert_in.z;
        b = vert_in.x;
      end
      default: begin
        a = vert_in.x;
        b = vert_in.y;
      end
    endcase
  end

  assign a_ext = {{(PROD_W-COORD_W){a[COORD_W-1]}}, a};
  assign b_ext = {{(PROD_W-COORD_W){b[COORD_W-1]}}, b};
  assign c_ext = {{(PROD_W-COEF_W){cos_rot[COEF_W-1]}}, cos_rot};
  assign s_ext = {{(PROD_W-SIN_W){sin_s[SIN_W-1]}}, sin_s};

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_m <= '0;
    end else begin
      tag_m <= tag_in;
    end
    idx_m  <= idx_in;
    vert_m <= vert_in;
    p_ac   <= a_ext * c_ext;
    p_bs   <= b_ext * s_ext;
    p_as   <= a_ext * s_ext;
    p_bc   <= b_ext * c_ext;
  end

  // Sums are floored by the arithmetic shift and then clamped.
  assign sum_a = {p_ac[PROD_W-1], p_ac} - {p_bs[PROD_W-1], p_bs};
  assign sum_b = {p_as[PROD_W-1], p_as} + {p_bc[PROD_W-1], p_bc};
  assign ra    = sat_coord(sum_a[SUM_W-1:COEF_BITS]);
  assign rb    = sat_coord(sum_b[SUM_W-1:COEF_BITS]);

  always_comb begin
    vert_next = vert_m;
    case (axis)
      AXIS_X: begin
        vert_next.y = ra;
        vert_next.z = rb;
      end
      AXIS_Y: begin
        vert_next.z = ra;
        vert_next.x = rb;
      end
      AXIS_Z: begin
        vert_next.x = ra;
        vert_next.y = rb;
      end
      default: begin
        vert_next = vert_m;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_m;
    end
    idx_out  <= idx_m;
    vert_out <= vert_next;
  end

endmodule

`default_nettype wire

[sv/cro_project.sv]
`timescale 1ns / 1ps
`default_nettype none

module cro_project
  import cro_pkg::*;
#(
  parameter int IDX_W         = 3,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [COEF_W-1:0] proj_kx,
  input  wire logic [COEF_W-1:0] proj_ky,
  input  wire cro_tag_t          tag_in,
  input  wire logic [IDX_W-1:0]  idx_in,
  input  wire vertex_t           vert_in,
  output logic                   strobe,
  output cro_result_t            result
);

  localparam int TW = PX_W - FRACTION_BITS;

  logic [PPROD_W-1:0] z_ext, kx_ext, ky_ext;

  cro_tag_t           tag_m;
  logic [IDX_W-1:0]   idx_m;
  logic [COORD_W-1:0] x_m, y_m;
  logic [PPROD_W-1:0] qx, qy;

  logic [PX_W-1:0]     px, py;
  logic [SCREEN_W-1:0] sx, sy;

  assign z_ext  = {{(PPROD_W-COORD_W){vert_in.z[COORD_W-1]}}, vert_in.z};
  assign kx_ext = {{(PPROD_W-COEF_W){proj_kx[COEF_W-1]}}, proj_kx};
  assign ky_ext = {{(PPROD_W-COEF_W){proj_ky[COEF_W-1]}}, proj_ky};

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_m <= '0;
    end else begin
      tag_m <= tag_in;
    end
    idx_m <= idx_in;
    x_m   <= vert_in.x;
    y_m   <= vert_in.y;
    qx    <= z_ext * kx_ext;
    qy    <= z_ext * ky_ext;
  end

  assign px = {{(PX_W-COORD_W){x_m[COORD_W-1]}}, x_m}
            + {qx[PPROD_W-1], qx[PPROD_W-1:COEF_BITS]};
  assign py = {{(PX_W-COORD_W){y_m[COORD_W-1]}}, y_m}
            + {qy[PPROD_W-1], qy[PPROD_W-1:COEF_BITS]};

  // Drop the fraction toward zero, then clamp to the screen range.
  function automatic logic [SCREEN_W-1:0] to_screen(input logic [PX_W-1:0] v);
    logic [TW-1:0]          t;
    logic [TW-SCREEN_W:0]   top;
    t   = v[PX_W-1:FRACTION_BITS] + TW'(v[PX_W-1] && (|v[FRACTION_BITS-1:0]));
    top = t[TW-1:SCREEN_W-1];
    if (&top || ~|top) begin
      return t[SCREEN_W-1:0];
    end else if (t[TW-1]) begin
      return SCREEN_MIN;
    end else begin
      return SCREEN_MAX;
    end
  endfunction

  assign sx = to_screen(px);
  assign sy = to_screen(py);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= tag_m.valid;
    end
    result.vertex_index <= 3'(idx_m);
    result.screen_x     <= sx;
    result.screen_y     <= sy;
    result.last_vertex  <= tag_m.last;
  end

endmodule

`default_nettype wire

[sv/cube_rotate_oblique_project.sv]
`timescale 1ns / 1ps
`default_nettype none

// Cube rotation with oblique projection.
//
// The block holds VERTEX_COUNT 3D vertices (Q15.16 by default) in a small
// synchronous RAM; after reset they read as the corners of a cube of side 100.
// A command word (axis, direction) is taken at a clock edge where start is high
// and busy is low. Every vertex is then read, rotated about the axis by the
// step angle in the cos_rot and sin_rot registers (AXIS_NONE leaves it as it
// is), written back, and projected with proj_kx and proj_ky. One result word
// per vertex, in index order, comes out on result for a single cycle with
// strobe high; the last carries last_vertex. The receiver cannot stall, so
// every result must be taken. Timing: one vertex is read per cycle, and busy
// stays high until the last result has been shown. The datapath is the
// five-stage read / multiply / sum / multiply / add chain behind the RAM read
// port. Registers are written through cfg_we, cfg_index and cfg_data; the
// user must write them only while busy is low, as the block does not enforce
// it. Reset restores the register defaults and marks every RAM entry as
// unwritten, so it reads as its cube corner; there is no clearing pass.

module cube_rotate_oblique_project
  import cro_pkg::*;
#(
  parameter int VERTEX_COUNT  = VERTEX_COUNT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire cro_cmd_t             cmd,
  output logic                      busy,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data,
  output logic                      strobe,
  output cro_result_t               result
);

  localparam int IDX_W = $clog2(VERTEX_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VERTEX_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;

  logic [COEF_W-1:0] cos_rot, sin_rot, proj_kx, proj_ky;
  logic [1:0]        axis;
  logic              direction;
  logic [SIN_W-1:0]  sin_ext, sin_s;

  logic [IDX_W-1:0]        rd_idx;
  logic [VERTEX_COUNT-1:0] written;
  logic                    ram_re;
  vertex_t                 ram_rdata;

  cro_tag_t         tag_rd;
  logic [IDX_W-1:0] idx_rd;
  vertex_t          vert_rd;

  cro_tag_t         tag_rot;
  logic [IDX_W-1:0] idx_rot;
  vertex_t          vert_rot;

  // Configuration registers. Only the four defined indexes exist.
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_rot <= COS_RESET;
      sin_rot <= SIN_RESET;
      proj_kx <= KX_RESET;
      proj_ky <= KY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COS: cos_rot <= cfg_data;
        REG_SIN: sin_rot <= cfg_data;
        REG_KX:  proj_kx <= cfg_data;
        REG_KY:  proj_ky <= cfg_data;
        default: ;
      endcase
    end
  end

  // The sine is widened by one bit so that negating the most negative value
  // stays exact.
  assign sin_ext = {sin_rot[COEF_W-1], sin_rot};
  assign sin_s   = direction ? -sin_ext : sin_ext;

  // Sequencer: one RAM read per cycle, then wait for the pipeline to drain.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (rd_idx == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (strobe && result.last_vertex) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        rd_idx <= '0;
      end else if (state == ST_ISSUE && rd_idx != LAST_IDX) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
    end
  end

  // The command word is held for the whole run.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      axis      <= cmd.axis;
      direction <= cmd.direction;
    end
  end

  assign busy   = (state != ST_IDLE);
  assign ram_re = (state == ST_ISSUE);

  // Tag of the word in flight through the RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd <= '0;
    end else begin
      tag_rd.valid <= ram_re;
      tag_rd.last  <= (rd_idx == LAST_IDX);
    end
    idx_rd <= rd_idx;
  end

  // Entries that were never written back read as their cube corner.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (tag_rot.valid) begin
      written[idx_rot] <= 1'b1;
    end
  end

  assign vert_rd = written[idx_rd] ? ram_rdata
                                   : cube_corner(32'(idx_rd), FRACTION_BITS);

  // Each entry is written back once its read has passed the RAM read register
  // and both rotate registers; within one run the read and write addresses
  // never meet, and a new run starts only after every write of the last one.
  cro_ram #(
    .WIDTH ($bits(vertex_t)),
    .DEPTH (VERTEX_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (tag_rot.valid),
    .waddr (idx_rot),
    .wdata (vert_rot),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  cro_rotate #(
    .IDX_W (IDX_W)
  ) u_rotate (
    .clk      (clk),
    .rst      (rst),
    .axis     (axis),
    .cos_rot  (cos_rot),
    .sin_s    (sin_s),
    .tag_in   (tag_rd),
    .idx_in   (idx_rd),
    .vert_in  (vert_rd),
    .tag_out  (tag_rot),
    .idx_out  (idx_rot),
    .vert_out (vert_rot)
  );

  cro_project #(
    .IDX_W         (IDX_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_project (
    .clk     (clk),
    .rst     (rst),
    .proj_kx (proj_kx),
    .proj_ky (proj_ky),
    .tag_in  (tag_rot),
    .idx_in  (idx_rot),
    .vert_in (vert_rot),
    .strobe  (strobe),
    .result  (result)
  );

`ifndef ASSERT_OFF
  // A result word only appears while a run is in progress.
  assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result word outside a run");

  // Write-back never targets the entry being read in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    (ram_re && tag_rot.valid) |-> (rd_idx != idx_rot))
    else $error("read and write-back collide on one entry");

  // A new command finds the pipeline empty.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> !(tag_rd.valid || tag_rot.valid || strobe))
    else $error("command accepted with vertices in flight");

  // The last vertex ends the run.
  assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_vertex) |=> !busy)
    else $error("run did not end after the last vertex");
`endif

endmodule

`default_nettype wire
